// File: hw/rtl/ddoi_pkg.sv
// ---------------------------------------------------------------------------
// ddoi_pkg
// Shared types, constants and helper functions for the odometry integrator.
// ---------------------------------------------------------------------------
package ddoi_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int NUM_W = 56;   // operand / numerator width of the arithmetic unit
  localparam int DEN_W = 34;   // multiplier / divisor width
  localparam int RES_W = 64;   // product / quotient width
  localparam int CNT_W = 6;    // holds NUM_W

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN    = 2'd0;
  localparam logic [1:0] REG_INV_RAD = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [23:0] GAIN_RST    = 24'd175922;
  localparam logic [23:0] INV_RAD_RST = 24'd655360;
  localparam logic [23:0] TIMEOUT_RST = 24'd1000000;

  localparam int SCALE_SH = 24 - FRAC_BITS;
  localparam int RATE_SH  = 16;
  localparam int THETA_SH = 40 - FRAC_BITS;
  localparam int ANG_SH   = 30 - FRAC_BITS;

  localparam logic [DEN_W-1:0] US_PER_S      = 34'd1000000;
  localparam logic [DEN_W-1:0] TWO_US_PER_S  = 34'd2000000;
  localparam logic [DEN_W-1:0] DEG100_TO_RAD = 34'd191900981;
  localparam logic [DEN_W-1:0] Q30_TWO_PI_U  = 34'd6746518852;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic {OP_MUL, OP_DIV} mdu_op_t;

  typedef struct packed {
    logic                    start;
    mdu_op_t                 op;
    logic signed [NUM_W-1:0] a;
    logic [DEN_W-1:0]        b;
    logic                    b_neg;
  } mdu_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] result;
    logic [DEN_W-1:0]        rem;
  } mdu_rsp_t;

  function automatic logic signed [23:0] sat24(input logic signed [RES_W-1:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = 24'sh7FFFFF;
    else if (v < -64'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/ddoi_mdu.sv
// ---------------------------------------------------------------------------
// ddoi_mdu
// Bit-serial multiply and floor-divide unit, one bit per cycle.
// ---------------------------------------------------------------------------
module ddoi_mdu (
  input  logic               clk,
  input  logic               rst,
  input  ddoi_pkg::mdu_req_t req,
  output ddoi_pkg::mdu_rsp_t rsp
);
  import ddoi_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

  mstate_t                 state;
  logic signed [RES_W-1:0] acc;
  logic signed [RES_W-1:0] mcand;
  logic [DEN_W-1:0]        mplier;
  logic                    neg;
  logic [NUM_W-1:0]        quo;
  logic [DEN_W-1:0]        rem;
  logic [DEN_W-1:0]        den;
  logic [CNT_W-1:0]        cnt;

  logic [DEN_W:0]          trial;
  logic                    fits;
  logic signed [RES_W-1:0] q_ext;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign q_ext = RES_W'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      unique case (state)
        M_IDLE: begin
          rsp.done <= 1'b0;
          if (req.start) begin
            neg <= (req.op == OP_MUL) ? req.b_neg : req.a[NUM_W-1];
            if (req.op == OP_MUL) begin
              acc    <= '0;
              mcand  <= RES_W'(req.a);
              mplier <= req.b;
              state  <= M_MUL;
            end else begin
              quo   <= req.a[NUM_W-1] ? NUM_W'(-req.a) : req.a;
              rem   <= '0;
              den   <= req.b;
              cnt   <= '0;
              state <= M_DIV;
            end
          end
        end
        M_MUL: begin
          if (mplier == '0) begin
            rsp.result <= neg ? -acc : acc;
            rsp.done   <= 1'b1;
            state      <= M_IDLE;
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= mcand <<< 1;
            mplier <= mplier >> 1;
          end
        end
        M_DIV: begin
          if (cnt == CNT_W'(NUM_W)) begin
            // Floor semantics for a negative numerator.
            if (neg) begin
              rsp.result <= (rem != '0) ? ~q_ext : -q_ext;
              rsp.rem    <= (rem != '0) ? den - rem : '0;
            end else begin
              rsp.result <= q_ext;
              rsp.rem    <= rem;
            end
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else begin
            rem <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
            quo <= {quo[NUM_W-2:0], fits};
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/diff_drive_odometry_integrator_unit.sv
// Results are computed by the shared bit-serial multiply/divide unit (up to eighteen
// operations in turn) and by a CORDIC rotation.
// One word is in flight at a time; the next word is accepted once the previous result sits
// in the output register.
// Synchronous reset clears pose, held speeds, timers and restores register defaults.
// ---------------------------------------------------------------------------
// diff_drive_odometry_integrator_unit
// Differential-drive odometry: integrates wheel speeds and yaw into a pose.
// ---------------------------------------------------------------------------
module diff_drive_odometry_integrator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               reset_pose,
  input  logic               report_valid,
  input  logic signed [15:0] left_speed_rpm,
  input  logic signed [15:0] right_speed_rpm,
  input  logic signed [23:0] yaw_centideg,
  input  logic [19:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [23:0] linear_speed,
  output logic signed [23:0] turn_rate,
  output logic signed [31:0] left_wheel_angle,
  output logic signed [31:0] right_wheel_angle,
  output logic signed [23:0] left_wheel_rate,
  output logic signed [23:0] right_wheel_rate
);
  import ddoi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCL_L, S_SCL_R, S_TMO, S_WL, S_WR, S_DL_M, S_DL_D, S_DR_M, S_DR_D,
    S_DS_M, S_DS_D, S_TH, S_MOD, S_CORD, S_X, S_Y, S_LIN_M, S_LIN_D, S_TRN_M,
    S_TRN_D, S_FIN
  } state_t;

  state_t state;
  logic   wait_unit;

  logic [23:0] gain, inv_rad, timeout;

  logic signed [31:0] x_acc, y_acc, head_acc, prev_yaw, la_acc, ra_acc;
  logic signed [23:0] held_yaw, hl, hr;
  logic [23:0]        since;

  logic signed [15:0] lrpm, rrpm;
  logic [19:0]        dt;
  logic signed [23:0] wl, wr, lin, turn;
  logic signed [24:0] ds;
  logic signed [31:0] theta;
  logic signed [32:0] dth;
  logic signed [33:0] xc, yc, zc, cc, sc;
  logic [4:0]         k;
  logic               cneg;

  mdu_req_t req;
  mdu_rsp_t rsp;

  ddoi_mdu u_mdu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic               accept;
  logic [24:0]        since_sum;
  logic signed [33:0] mid;
  logic signed [35:0] fold0, fold1;
  logic               fold_neg;
  logic signed [33:0] dx, dy, at;
  logic signed [23:0] theta_dth_unused;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign since_sum = {1'b0, since} + 25'(elapsed_us);

  assign mid = 34'(head_acc) + 34'(dth >>> 1);

  // Fold the reduced angle into [-pi/2, pi/2], remembering a sign flip.
  always_comb begin
    fold0 = {2'b00, rsp.rem};
    if (fold0 > Q30_PI) fold0 = fold0 - Q30_TWO_PI;
    fold1    = fold0;
    fold_neg = 1'b0;
    if (fold0 > Q30_HALF_PI) begin
      fold1    = fold0 - Q30_PI;
      fold_neg = 1'b1;
    end else if (fold0 < -Q30_HALF_PI) begin
      fold1    = fold0 + Q30_PI;
      fold_neg = 1'b1;
    end
  end

  assign dx = yc >>> k;
  assign dy = xc >>> k;
  assign at = atan_q30(k);
  assign theta_dth_unused = '0;

  always_comb begin
    req       = '0;
    req.op    = OP_MUL;
    req.start = !wait_unit;
    unique case (state)
      S_SCL_L: begin req.a = NUM_W'(lrpm); req.b = DEN_W'(gain); end
      S_SCL_R: begin req.a = NUM_W'(rrpm); req.b = DEN_W'(gain); end
      S_WL:    begin req.a = NUM_W'(hl); req.b = DEN_W'(inv_rad); end
      S_WR:    begin req.a = NUM_W'(hr); req.b = DEN_W'(inv_rad); end
      S_DL_M:  begin req.a = NUM_W'(wl); req.b = DEN_W'(dt); end
      S_DR_M:  begin req.a = NUM_W'(wr); req.b = DEN_W'(dt); end
      S_DS_M:  begin req.a = NUM_W'(hl) + NUM_W'(hr); req.b = DEN_W'(dt); end
      S_TH:    begin req.a = NUM_W'(held_yaw); req.b = DEG100_TO_RAD; end
      S_X:     begin
        req.a = NUM_W'(ds); req.b = cc[33] ? DEN_W'(-cc) : cc; req.b_neg = cc[33];
      end
      S_Y:     begin
        req.a = NUM_W'(ds); req.b = sc[33] ? DEN_W'(-sc) : sc; req.b_neg = sc[33];
      end
      S_LIN_M: begin
        req.a = NUM_W'(ds); req.b = US_PER_S; req.start = !wait_unit && (dt != '0);
      end
      S_TRN_M: begin req.a = NUM_W'(dth); req.b = US_PER_S; end
      S_DL_D, S_DR_D, S_LIN_D, S_TRN_D: begin
        req.op = OP_DIV; req.a = rsp.result[NUM_W-1:0];
        req.b  = (state == S_DL_D || state == S_DR_D) ? US_PER_S : DEN_W'(dt);
      end
      S_DS_D:  begin req.op = OP_DIV; req.a = rsp.result[NUM_W-1:0]; req.b = TWO_US_PER_S; end
      S_MOD:   begin
        req.op = OP_DIV;
        req.a  = NUM_W'(mid) <<< ANG_SH;
        req.b  = Q30_TWO_PI_U;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_unit <= 1'b0;
      out_valid <= 1'b0;
      gain      <= GAIN_RST;
      inv_rad   <= INV_RAD_RST;
      timeout   <= TIMEOUT_RST;
      x_acc     <= '0;
      y_acc     <= '0;
      head_acc  <= '0;
      prev_yaw  <= '0;
      held_yaw  <= '0;
      hl        <= '0;
      hr        <= '0;
      since     <= '0;
      la_acc    <= '0;
      ra_acc    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN:    gain    <= cfg_data;
          REG_INV_RAD: inv_rad <= cfg_data;
          REG_TIMEOUT: timeout <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      if (req.start) wait_unit <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lrpm <= left_speed_rpm;
            rrpm <= right_speed_rpm;
            dt   <= elapsed_us;
            if (reset_pose) begin
              x_acc <= '0; y_acc <= '0; head_acc <= '0;
              hl <= '0; hr <= '0;
              la_acc <= '0; ra_acc <= '0;
            end
            if (report_valid) begin
              held_yaw <= yaw_centideg;
              since    <= '0;
              state    <= S_SCL_L;
            end else begin
              if (reset_pose) held_yaw <= '0;
              since <= since_sum[24] ? 24'hFFFFFF : since_sum[23:0];
              state <= S_TMO;
            end
          end
        end
        S_SCL_L: if (wait_unit && rsp.done) begin
          hl <= sat24(rsp.result >>> SCALE_SH); wait_unit <= 1'b0; state <= S_SCL_R;
        end
        S_SCL_R: if (wait_unit && rsp.done) begin
          hr <= sat24(rsp.result >>> SCALE_SH); wait_unit <= 1'b0; state <= S_TMO;
        end
        S_TMO: begin
          if (since > timeout) begin
            hl <= '0;
            hr <= '0;
          end
          state <= S_WL;
        end
        S_WL: if (wait_unit && rsp.done) begin
          wl <= sat24(rsp.result >>> RATE_SH); wait_unit <= 1'b0; state <= S_WR;
        end
        S_WR: if (wait_unit && rsp.done) begin
          wr <= sat24(rsp.result >>> RATE_SH); wait_unit <= 1'b0; state <= S_DL_M;
        end
        S_DL_M: if (wait_unit && rsp.done) begin wait_unit <= 1'b0; state <= S_DL_D; end
        S_DL_D: if (wait_unit && rsp.done) begin
          la_acc <= la_acc + rsp.result[31:0]; wait_unit <= 1'b0; state <= S_DR_M;
        end
        S_DR_M: if (wait_unit && rsp.done) begin wait_unit <= 1'b0; state <= S_DR_D; end
        S_DR_D: if (wait_unit && rsp.done) begin
          ra_acc <= ra_acc + rsp.result[31:0]; wait_unit <= 1'b0; state <= S_DS_M;
        end
        S_DS_M: if (wait_unit && rsp.done) begin wait_unit <= 1'b0; state <= S_DS_D; end
        S_DS_D: if (wait_unit && rsp.done) begin
          ds <= rsp.result[24:0]; wait_unit <= 1'b0; state <= S_TH;
        end
        S_TH: if (wait_unit && rsp.done) begin
          theta <= rsp.result[THETA_SH+31:THETA_SH];
          dth   <= 33'($signed(rsp.result[THETA_SH+31:THETA_SH])) - 33'(prev_yaw);
          wait_unit <= 1'b0;
          state <= S_MOD;
        end
        S_MOD: if (wait_unit && rsp.done) begin
          zc   <= fold1[33:0];
          cneg <= fold_neg;
          xc   <= CORDIC_GAIN;
          yc   <= '0;
          k    <= '0;
          wait_unit <= 1'b0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (k == 5'(CORDIC_STEPS)) begin
            cc    <= cneg ? -xc : xc;
            sc    <= cneg ? -yc : yc;
            state <= S_X;
          end else begin
            if (!zc[33]) begin
              xc <= xc - dx; yc <= yc + dy; zc <= zc - at;
            end else begin
              xc <= xc + dx; yc <= yc - dy; zc <= zc + at;
            end
            k <= k + 1'b1;
          end
        end
        S_X: if (wait_unit && rsp.done) begin
          x_acc <= x_acc + rsp.result[61:30]; wait_unit <= 1'b0; state <= S_Y;
        end
        S_Y: if (wait_unit && rsp.done) begin
          y_acc <= y_acc + rsp.result[61:30]; wait_unit <= 1'b0; state <= S_LIN_M;
        end
        S_LIN_M: begin
          if (dt == '0) begin
            lin   <= theta_dth_unused;
            turn  <= '0;
            state <= S_FIN;
          end else if (wait_unit && rsp.done) begin
            wait_unit <= 1'b0; state <= S_LIN_D;
          end
        end
        S_LIN_D: if (wait_unit && rsp.done) begin
          lin <= sat24(rsp.result); wait_unit <= 1'b0; state <= S_TRN_M;
        end
        S_TRN_M: if (wait_unit && rsp.done) begin wait_unit <= 1'b0; state <= S_TRN_D; end
        S_TRN_D: if (wait_unit && rsp.done) begin
          turn <= sat24(rsp.result); wait_unit <= 1'b0; state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            head_acc          <= head_acc + dth[31:0];
            prev_yaw          <= theta;
            pos_x             <= x_acc;
            pos_y             <= y_acc;
            heading           <= head_acc + dth[31:0];
            linear_speed      <= lin;
            turn_rate         <= turn;
            left_wheel_angle  <= la_acc;
            right_wheel_angle <= ra_acc;
            left_wheel_rate   <= wl;
            right_wheel_rate  <= wr;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/diff_drive_odometry_integrator_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// diff_drive_odometry_integrator_unit_tb
// Drives update ticks through the odometry integrator under random valid and
// stall gaps, predicts every pose word in fixed point and compares field by field.
// ---------------------------------------------------------------------------
module diff_drive_odometry_integrator_unit_tb;
  import ddoi_pkg::*;

  typedef struct {
    logic               clr;
    logic               rep;
    logic signed [15:0] lrpm;
    logic signed [15:0] rrpm;
    logic signed [23:0] yaw;
    logic [19:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] x, y, hd;
    logic signed [23:0] lin, turn;
    logic signed [31:0] lang, rang;
    logic signed [23:0] lrate, rrate;
  } pose_t;

  localparam longint TWO_PI_Q30  = 64'd6746518852;
  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint GAIN_Q30    = 64'd652032874;
  localparam longint DEG_Q40     = 64'd191900981;
  localparam longint USEC        = 64'd1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_GAIN;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic reset_pose = 1'b0, report_valid = 1'b0;
  logic signed [15:0] left_speed_rpm = '0, right_speed_rpm = '0;
  logic signed [23:0] yaw_centideg = '0;
  logic [19:0] elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, heading, left_wheel_angle, right_wheel_angle;
  logic signed [23:0] linear_speed, turn_rate, left_wheel_rate, right_wheel_rate;

  diff_drive_odometry_integrator_unit dut (.*);

  always #4 clk = ~clk;

  tick_t  pending_ticks[$];
  pose_t  expected_poses[$];
  int     mismatches = 0;
  logic   quiet = 1'b0;

  // Model state and register copies.
  longint gain_r, inv_rad_r, timeout_r;
  longint x_s, y_s, hd_s, prev_yaw_s, held_yaw_s, lspd_s, rspd_s, age_s, lang_s, rang_s;
  longint atan_tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                           524287, 262143, 131071, 65535, 32767};

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint wrap_32(longint v);
    logic signed [31:0] t;
    t = v[31:0];
    return longint'(t);
  endfunction

  task automatic rotate_heading(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = ang * (64'd1 << 14);
    x = GAIN_Q30; y = 0; flip = 0;
    r = r - floor_div(r, TWO_PI_Q30) * TWO_PI_Q30;
    if (r > PI_Q30) r = r - TWO_PI_Q30;
    if (r > HALF_PI_Q30) begin
      r = r - PI_Q30; flip = 1;
    end else if (r < -HALF_PI_Q30) begin
      r = r + PI_Q30; flip = 1;
    end
    z = r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic reset_odometry();
    gain_r = longint'(GAIN_RST); inv_rad_r = longint'(INV_RAD_RST);
    timeout_r = longint'(TIMEOUT_RST);
    x_s = 0; y_s = 0; hd_s = 0; prev_yaw_s = 0; held_yaw_s = 0;
    lspd_s = 0; rspd_s = 0; age_s = 0; lang_s = 0; rang_s = 0;
  endtask

  task automatic integrate_tick(input tick_t t);
    longint dt, wl, wr, dl, dr, ds, theta, dth, mid, c, s, lin, turn;
    pose_t p;
    dt = longint'(t.dt); lin = 0; turn = 0;
    if (t.clr) begin
      x_s = 0; y_s = 0; hd_s = 0; held_yaw_s = 0;
      lspd_s = 0; rspd_s = 0; lang_s = 0; rang_s = 0;
    end
    if (t.rep) begin
      lspd_s = clamp24((longint'(t.lrpm) * gain_r) >>> 8);
      rspd_s = clamp24((longint'(t.rrpm) * gain_r) >>> 8);
      held_yaw_s = longint'(t.yaw);
      age_s = 0;
    end else begin
      age_s = age_s + dt;
      if (age_s > 24'hFFFFFF) age_s = 24'hFFFFFF;
    end
    if (age_s > timeout_r) begin
      lspd_s = 0; rspd_s = 0;
    end
    wl = clamp24((lspd_s * inv_rad_r) >>> 16);
    wr = clamp24((rspd_s * inv_rad_r) >>> 16);
    dl = floor_div(wl * dt, USEC);
    dr = floor_div(wr * dt, USEC);
    ds = floor_div((lspd_s + rspd_s) * dt, 2 * USEC);
    theta = (held_yaw_s * DEG_Q40) >>> 24;
    dth = theta - prev_yaw_s;
    mid = hd_s + (dth >>> 1);
    rotate_heading(mid, c, s);
    x_s = wrap_32(x_s + ((ds * c) >>> 30));
    y_s = wrap_32(y_s + ((ds * s) >>> 30));
    hd_s = wrap_32(hd_s + dth);
    if (dt != 0) begin
      lin = clamp24(floor_div(ds * USEC, dt));
      turn = clamp24(floor_div(dth * USEC, dt));
    end
    lang_s = wrap_32(lang_s + dl);
    rang_s = wrap_32(rang_s + dr);
    prev_yaw_s = wrap_32(theta);
    p.x = x_s[31:0]; p.y = y_s[31:0]; p.hd = hd_s[31:0];
    p.lin = lin[23:0]; p.turn = turn[23:0];
    p.lang = lang_s[31:0]; p.rang = rang_s[31:0];
    p.lrate = wl[23:0]; p.rrate = wr[23:0];
    expected_poses.insert(expected_poses.size(), p);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Driver: acceptance is observed at the rising edge, new words go out at the falling one.
  bit taken = 0;
  int in_gap = 0;
  int out_gap = 0;
  tick_t cur;

  always @(posedge clk) begin
    taken <= (!rst && in_valid && !in_stall);
    if (!rst && in_valid && !in_stall) integrate_tick(cur);
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || taken)) begin
      if (in_gap > 0 || pending_ticks.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        cur = pending_ticks.pop_front();
        reset_pose <= cur.clr; report_valid <= cur.rep;
        left_speed_rpm <= cur.lrpm; right_speed_rpm <= cur.rrpm;
        yaw_centideg <= cur.yaw; elapsed_us <= cur.dt;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end
    end
  end

  // Monitor side: stall runs of random length and the field comparison.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(99) < 15) out_gap <= pick_gap();
      end
    end
    if ($urandom_range(999) == 0) quiet <= ~quiet;
  end

  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = expected_poses.pop_front();
        if (pos_x !== e.x) report_mismatch("pos_x", longint'(pos_x), longint'(e.x));
        if (pos_y !== e.y) report_mismatch("pos_y", longint'(pos_y), longint'(e.y));
        if (heading !== e.hd)
          report_mismatch("heading", longint'(heading), longint'(e.hd));
        if (linear_speed !== e.lin)
          report_mismatch("linear_speed", longint'(linear_speed), longint'(e.lin));
        if (turn_rate !== e.turn)
          report_mismatch("turn_rate", longint'(turn_rate), longint'(e.turn));
        if (left_wheel_angle !== e.lang)
          report_mismatch("left_wheel_angle", longint'(left_wheel_angle), longint'(e.lang));
        if (right_wheel_angle !== e.rang)
          report_mismatch("right_wheel_angle", longint'(right_wheel_angle),
                          longint'(e.rang));
        if (left_wheel_rate !== e.lrate)
          report_mismatch("left_wheel_rate", longint'(left_wheel_rate), longint'(e.lrate));
        if (right_wheel_rate !== e.rrate)
          report_mismatch("right_wheel_rate", longint'(right_wheel_rate),
                          longint'(e.rrate));
      end
    end
  end

  task automatic add_tick(input int clr, input int rep, input int l, input int r,
                          input int yaw, input int dt);
    tick_t t;
    t.clr = clr[0]; t.rep = rep[0]; t.lrpm = 16'(l); t.rrpm = 16'(r);
    t.yaw = 24'(yaw); t.dt = 20'(dt);
    pending_ticks.insert(pending_ticks.size(), t);
  endtask

  task automatic add_random_ticks(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 75) begin
        // Typical drive tick: small speeds, yaw anywhere in +/-360 degrees, dt of tens of ms.
        add_tick(int'($urandom_range(99) < 3), int'($urandom_range(99) < 80),
                 $urandom_range(0, 6000) - 3000, $urandom_range(0, 6000) - 3000,
                 $urandom_range(0, 72000) - 36000, $urandom_range(5000, 120000));
      end else begin
        add_tick($urandom_range(1), $urandom_range(1), $urandom, $urandom, $urandom,
                 ($urandom_range(9) == 0) ? 0 : $urandom);
      end
    end
  endtask

  task automatic drain();
    wait (pending_ticks.size() == 0 && !in_valid && expected_poses.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN:    gain_r = longint'(val);
      REG_INV_RAD: inv_rad_r = longint'(val);
      REG_TIMEOUT: timeout_r = longint'(val);
      default: ;
    endcase
  endtask

  initial begin
    reset_odometry();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks: extreme speeds and yaws, zero and maximal dt, pose clear, timeout.
    add_tick(0, 1, 32767, -32768, 8388607, 1048575);
    add_tick(0, 1, -32768, 32767, -8388608, 0);
    add_tick(0, 0, 0, 0, 0, 0);
    add_tick(1, 1, 1000, 1000, 9000, 50000);
    add_tick(0, 1, 1000, -1000, 18000, 50000);
    add_tick(0, 1, 3000, 3000, -18000, 100000);
    add_tick(0, 0, -1, -1, 0, 1048575);
    add_tick(0, 0, 0, 0, 0, 1000);
    add_tick(1, 0, 5, 5, 5, 20000);
    add_tick(0, 1, 32767, 32767, 36000, 1);
    add_tick(0, 1, -32768, -32768, -36000, 1048575);
    add_tick(1, 1, 0, 0, 0, 0);
    add_random_ticks(190);
    drain();

    write_reg(REG_GAIN, 24'hFFFFFF);
    write_reg(REG_INV_RAD, 24'hFFFFFF);
    write_reg(REG_TIMEOUT, 24'd0);
    add_tick(0, 1, 32767, -32768, 100, 30000);
    add_tick(0, 0, 32767, -32768, 100, 30000);
    add_random_ticks(200);
    drain();

    write_reg(REG_GAIN, 24'd0);
    write_reg(REG_INV_RAD, 24'd0);
    write_reg(REG_TIMEOUT, 24'hFFFFFF);
    add_random_ticks(100);
    drain();

    write_reg(REG_GAIN, 24'd1);
    write_reg(REG_INV_RAD, 24'd1);
    write_reg(REG_TIMEOUT, 24'd200000);
    add_random_ticks(100);
    drain();

    write_reg(REG_GAIN, GAIN_RST);
    write_reg(REG_INV_RAD, INV_RAD_RST);
    write_reg(REG_TIMEOUT, 24'd50000);
    add_random_ticks(200);
    drain();
    repeat (1000) @(posedge clk);

    if (expected_poses.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
